### rtl/alad_pkg.sv
// Shared types, constants and the elaboration-time log2 helper for the
// ambient-light auto-dim block. No dependencies.
package alad_pkg;

  // Field widths
  localparam int COUNT_W     = 16;
  localparam int LEVEL_W     = 8;
  localparam int LUX_W       = 20;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  // Default number of fraction bits of the fixed-point log2
  localparam int LOG_FRACTION_BITS_DEF = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_PRESENT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTO_DIM_ENABLE = 8'd1;

  // Level mapping
  localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 8'd60;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_SPAN = 8'd195;
  localparam logic [COUNT_W-1:0] COUNT_LOW  = 16'd87;
  localparam logic [COUNT_W-1:0] COUNT_HIGH = 16'd17362;

  // Log2 operands: v = 5 * count needs 19 bits, its exponent 5 bits
  localparam int V_W    = 19;
  localparam int E_W    = 5;
  localparam int X_W    = 31;   // Q.30 mantissa in [1,2)
  localparam int Q_FRAC = 30;
  localparam int T_W    = 32;   // squared mantissa before renormalising
  localparam logic [31:0] LOG_REF_THRESH = 32'd434;
  localparam logic [31:0] LOG_REF_SPAN   = 32'd200;

  // lux_q8 = floor(count * 9216 / 625) = floor(count * 9 * LUX_MULT / 2^30)
  localparam int                   LUX_P_W   = 20;
  localparam int                   LUX_M_W   = 31;
  localparam int                   LUX_SHIFT = 30;
  localparam logic [LUX_M_W-1:0]   LUX_MULT  = 31'd1759218605;

  // Per-poll side data that travels next to the log2 pipeline
  typedef struct packed {
    logic               upd;   // sensor present and read good
    logic               en;    // auto-dim enabled
    logic               low;   // count below the ramp
    logic               high;  // count at or above the ramp top
    logic [LEVEL_W-1:0] cur;
  } side_t;

  // Fixed-point log2 of a constant, same bit-exact scheme as the datapath
  function automatic logic [31:0] log2_fixed(input logic [31:0] v, input int frac_bits);
    int          e;
    int          i;
    int          k;
    logic [63:0] x;
    logic [31:0] frac;
    e    = 0;
    frac = '0;
    for (i = 1; i < 32; i++) begin
      if ((v >> i) != 32'd0) begin
        e = i;
      end
    end
    x = 64'(v) << (30 - e);
    for (k = 0; k < frac_bits; k++) begin
      x    = (x * x) >> 30;
      frac = {frac[30:0], 1'b0};
      if (x >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        x       = x >> 1;
      end
    end
    return (32'(e) << frac_bits) | frac;
  endfunction

endpackage

### rtl/alad_lux.sv
// Lux conversion pipeline: count to Q.8 lux by reciprocal multiplication,
// delayed to line up with the log2 pipeline. Depends on alad_pkg.
module alad_lux #(
  parameter int LAT = alad_pkg::LOG_FRACTION_BITS_DEF + 1
) (
  input  logic                        clk,
  input  logic [alad_pkg::COUNT_W-1:0] count,
  output logic [alad_pkg::LUX_W-1:0]   lux
);
  import alad_pkg::*;

  localparam int PROD_W = LUX_P_W + LUX_M_W;

  logic [LUX_P_W-1:0] p9;
  logic [PROD_W-1:0]  prod;
  logic [LUX_W-1:0]   lux_d [0:LAT-2];

  // Multiply by nine with a shift and add
  always_ff @(posedge clk) begin
    p9 <= {1'b0, count, 3'b000} + LUX_P_W'(count);
  end

  // Multiply by the reciprocal and keep the quotient bits
  assign prod = PROD_W'(p9) * PROD_W'(LUX_MULT);

  always_ff @(posedge clk) begin
    lux_d[0] <= prod[LUX_SHIFT +: LUX_W];
  end

  // Delay line up to the log2 latency
  for (genvar k = 1; k <= LAT - 2; k++) begin : g_dly
    always_ff @(posedge clk) begin
      lux_d[k] <= lux_d[k-1];
    end
  end

  assign lux = lux_d[LAT-2];

endmodule

### rtl/alad_log2.sv
// Fixed-point log2 pipeline: leading-one stage, then one squaring stage per
// fraction bit, each with a valid bit. Depends on alad_pkg.
module alad_log2 #(
  parameter int FRAC_BITS = alad_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [alad_pkg::V_W-1:0] v,
  output logic                     out_valid,
  output logic [alad_pkg::E_W+FRAC_BITS-1:0] log_val
);
  import alad_pkg::*;

  localparam int SQ_W = 2 * X_W;

  logic [E_W-1:0]       e_det;
  logic [X_W-1:0]       x_lod;
  logic [X_W-1:0]       x_s    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] frac_s [0:FRAC_BITS];
  logic [E_W-1:0]       e_s    [0:FRAC_BITS];
  logic                 vld_s  [0:FRAC_BITS];
  logic [SQ_W-1:0]      sq     [1:FRAC_BITS];
  logic [T_W-1:0]       t_sq   [1:FRAC_BITS];

  // Find the leading one and normalise to Q.30
  always_comb begin
    e_det = '0;
    for (int i = 0; i < V_W; i++) begin
      if (v[i]) begin
        e_det = E_W'(i);
      end
    end
    x_lod = X_W'(v) << (E_W'(Q_FRAC) - e_det);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else begin
      vld_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      x_s[0]    <= x_lod;
      e_s[0]    <= e_det;
      frac_s[0] <= '0;
    end
  end

  // One squaring per fraction bit: square, take the bit, renormalise
  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_sq
    assign sq[i]   = SQ_W'(x_s[i-1]) * SQ_W'(x_s[i-1]);
    assign t_sq[i] = sq[i][Q_FRAC +: T_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i] <= 1'b0;
      end else begin
        vld_s[i] <= vld_s[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (vld_s[i-1]) begin
        x_s[i]    <= t_sq[i][T_W-1] ? t_sq[i][T_W-1:1] : t_sq[i][X_W-1:0];
        frac_s[i] <= {frac_s[i-1][FRAC_BITS-2:0], t_sq[i][T_W-1]};
        e_s[i]    <= e_s[i-1];
      end
    end
  end

  assign out_valid = vld_s[FRAC_BITS];
  assign log_val   = {e_s[FRAC_BITS], frac_s[FRAC_BITS]};

endmodule

### rtl/alad_level.sv
// Level stages: log difference times span, reciprocal divide to the target
// level, then the quarter-gap move. Depends on alad_pkg.
module alad_level #(
  parameter int FRAC_BITS = alad_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [alad_pkg::E_W+FRAC_BITS-1:0]   log_val,
  input  alad_pkg::side_t                      side,
  input  logic [alad_pkg::LUX_W-1:0]           lux_in,
  output logic                                 done,
  output logic [alad_pkg::LEVEL_W-1:0]         new_level,
  output logic                                 level_changed,
  output logic [alad_pkg::LUX_W-1:0]           lux_q8,
  output logic                                 lux_valid
);
  import alad_pkg::*;

  localparam int          A_W      = E_W + FRAC_BITS;
  localparam int          N_W      = A_W + LEVEL_W;
  localparam logic [31:0] LOG_B    = log2_fixed(LOG_REF_THRESH, FRAC_BITS);
  localparam logic [31:0] LOG_SPAN = log2_fixed(LOG_REF_SPAN, FRAC_BITS);
  localparam int          SPAN_L   = $clog2(LOG_SPAN);
  localparam int          SH       = N_W + SPAN_L;
  localparam int          M_W      = N_W + 1;
  localparam logic [63:0] DIV_M    = ((64'd1 << SH) + 64'(LOG_SPAN) - 64'd1) / 64'(LOG_SPAN);
  localparam int          P_W      = N_W + M_W;
  localparam int          Q_W      = P_W - SH;

  logic [A_W-1:0]     d;
  logic [N_W-1:0]     n1;
  side_t              side1;
  logic [LUX_W-1:0]   lux1;
  logic               vld1;
  logic [P_W-1:0]     prod;
  logic [Q_W-1:0]     q;
  logic [LEVEL_W-1:0] tgt_next;
  logic [LEVEL_W-1:0] tgt2;
  side_t              side2;
  logic [LUX_W-1:0]   lux2;
  logic               vld2;
  logic               up;
  logic [LEVEL_W-1:0] mag;
  logic [LEVEL_W-1:0] stepm;
  logic [LEVEL_W-1:0] new_level_next;
  logic               move;

  // Stage 1: log difference, clamped at zero, times the level span
  assign d = (log_val > A_W'(LOG_B)) ? (log_val - A_W'(LOG_B)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      n1    <= N_W'(d) * N_W'(LEVEL_SPAN);
      side1 <= side;
      lux1  <= lux_in;
    end
  end

  // Stage 2: divide by the log of the span ratio, pick the target level
  assign prod = P_W'(n1) * P_W'(DIV_M[M_W-1:0]);
  assign q    = prod[SH +: Q_W];

  always_comb begin
    if (side1.low) begin
      tgt_next = LEVEL_MIN;
    end else if (side1.high || (q > Q_W'(LEVEL_SPAN))) begin
      tgt_next = LEVEL_MAX;
    end else begin
      tgt_next = q[LEVEL_W-1:0] + LEVEL_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld1) begin
      tgt2  <= tgt_next;
      side2 <= side1;
      lux2  <= lux1;
    end
  end

  // Stage 3: move a quarter of the gap, at least one step
  assign up    = tgt2 > side2.cur;
  assign mag   = up ? (tgt2 - side2.cur) : (side2.cur - tgt2);
  assign stepm = (mag[LEVEL_W-1:2] == '0) ? LEVEL_W'(1) : LEVEL_W'(mag[LEVEL_W-1:2]);
  assign move  = side2.upd && side2.en && (tgt2 != side2.cur);

  always_comb begin
    if (!move) begin
      new_level_next = side2.cur;
    end else if (up) begin
      new_level_next = side2.cur + stepm;
    end else begin
      new_level_next = side2.cur - stepm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (vld2) begin
      new_level     <= new_level_next;
      level_changed <= move;
      lux_q8        <= side2.upd ? lux2 : '0;
      lux_valid     <= side2.upd;
    end
  end

endmodule

### rtl/ambient_light_backlight_auto_dim.sv
// Top level of the ambient-light auto-dim block: input stage, configuration
// registers, side-data line. Depends on alad_pkg, alad_lux, alad_log2, alad_level.
//
// One sensor poll is taken per clock cycle, at any edge where start is high
// and busy is low; busy is high only while rst is held. Each poll gives one
// result, marked by done for a single cycle. The poll passes through the
// input stage, the leading-one stage of the log2 unit, which then squares
// the mantissa once per fraction bit with one multiplier in each stage, and
// three level stages. The receiver cannot stall, so results are never held
// and a poll may follow every cycle. Configuration writes are always ready
// outside reset and take effect for polls taken after the write.
module ambient_light_backlight_auto_dim #(
  parameter int LOG_FRACTION_BITS = alad_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [alad_pkg::COUNT_W-1:0]    raw_count,
  input  logic                            read_ok,
  input  logic [alad_pkg::LEVEL_W-1:0]    current_level,
  output logic                            done,
  output logic [alad_pkg::LEVEL_W-1:0]    new_level,
  output logic                            level_changed,
  output logic [alad_pkg::LUX_W-1:0]      lux_q8,
  output logic                            lux_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [alad_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import alad_pkg::*;

  localparam int LOG_LAT   = LOG_FRACTION_BITS + 1;
  localparam int TOTAL_LAT = LOG_LAT + 4;

  logic               sensor_present;
  logic               auto_dim_enable;
  logic               accept;
  logic               vld0;
  logic [COUNT_W-1:0] count0;
  side_t              side0;
  side_t              side_d [0:LOG_LAT-1];
  logic [V_W-1:0]     v5;
  logic               log_valid;
  logic [E_W+LOG_FRACTION_BITS-1:0] log_val;
  logic [LUX_W-1:0]   lux_al;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_present  <= 1'b1;
      auto_dim_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENSOR_PRESENT:  sensor_present  <= cfg_data[0];
        REG_AUTO_DIM_ENABLE: auto_dim_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input stage: capture the transaction and classify the count
  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count0     <= raw_count;
      side0.upd  <= sensor_present && read_ok;
      side0.en   <= auto_dim_enable;
      side0.low  <= raw_count < COUNT_LOW;
      side0.high <= raw_count >= COUNT_HIGH;
      side0.cur  <= current_level;
    end
  end

  // Five times the count, the operand of the log
  assign v5 = {1'b0, count0, 2'b00} + V_W'(count0);

  // Hold the side data alongside the log2 pipeline
  always_ff @(posedge clk) begin
    side_d[0] <= side0;
  end

  for (genvar k = 1; k < LOG_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      side_d[k] <= side_d[k-1];
    end
  end

  alad_log2 #(
    .FRAC_BITS (LOG_FRACTION_BITS)
  ) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld0),
    .v         (v5),
    .out_valid (log_valid),
    .log_val   (log_val)
  );

  alad_lux #(
    .LAT (LOG_LAT)
  ) u_lux (
    .clk   (clk),
    .count (count0),
    .lux   (lux_al)
  );

  alad_level #(
    .FRAC_BITS (LOG_FRACTION_BITS)
  ) u_level (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (log_valid),
    .log_val       (log_val),
    .side          (side_d[LOG_LAT-1]),
    .lux_in        (lux_al),
    .done          (done),
    .new_level     (new_level),
    .level_changed (level_changed),
    .lux_q8        (lux_q8),
    .lux_valid     (lux_valid)
  );

  // Every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##TOTAL_LAT done)
    else $error("result missing after pipeline latency");

  // A level only moves on a good read
  a_change_needs_read: assert property (@(posedge clk) disable iff (rst)
    (done && level_changed) |-> lux_valid)
    else $error("level moved without a valid read");

  // Lux reads zero and the level does not move when the read is not valid
  a_lux_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !lux_valid) |-> (lux_q8 == '0) && !level_changed)
    else $error("lux or level reported for an invalid read");

endmodule

### bench/alad_checker.sv
`timescale 1ns / 1ps
// Scoreboard for ambient_light_backlight_auto_dim: shadows the two configuration
// registers, predicts the result of every accepted poll and compares it field by
// field with what the block returns. Depends on alad_pkg.
module alad_checker #(
  parameter int LOG_BITS = alad_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [alad_pkg::COUNT_W-1:0]     raw_count,
  input  logic                             read_ok,
  input  logic [alad_pkg::LEVEL_W-1:0]     current_level,
  input  logic                             done,
  input  logic [alad_pkg::LEVEL_W-1:0]     new_level,
  input  logic                             level_changed,
  input  logic [alad_pkg::LUX_W-1:0]       lux_q8,
  input  logic                             lux_valid,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [alad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [alad_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatch_count,
  output int                               results_owed
);
  import alad_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] new_level;
    logic               level_changed;
    logic [LUX_W-1:0]   lux_q8;
    logic               lux_valid;
  } poll_result_t;

  poll_result_t pending_results[$];
  logic         present_r = 1'b1;
  logic         enable_r  = 1'b1;
  int           fails     = 0;
  int           owed_r    = 0;

  assign mismatch_count = fails;
  assign results_owed   = owed_r;

  // Log2 in Q.LOG_BITS: leading-one position, then repeated squaring of the mantissa
  function automatic logic [31:0] log2_q(input logic [31:0] v);
    int          msb;
    int          b;
    int          k;
    logic [63:0] mant;
    logic [31:0] frac;
    msb  = 0;
    frac = '0;
    for (b = 1; b < 30; b++) begin
      if (v[b]) begin
        msb = b;
      end
    end
    mant = {32'd0, v} << (30 - msb);
    for (k = 0; k < LOG_BITS; k++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        mant    = mant >> 1;
      end
    end
    return (32'(msb) << LOG_BITS) | frac;
  endfunction

  // Brightness the ambient count asks for: flat at both ends, log ramp between
  function automatic int ramp_target(input logic [COUNT_W-1:0] count);
    logic [31:0] lit;
    logic [31:0] dark;
    logic [31:0] above;
    int          lvl;
    if (count < 16'd87) begin
      return 60;
    end
    if (count >= 16'd17362) begin
      return 255;
    end
    lit   = log2_q(32'(count) * 32'd5);
    dark  = log2_q(32'd434);
    above = (lit > dark) ? (lit - dark) : 32'd0;
    lvl   = 60 + int'((above * 32'd195) / log2_q(32'd200));
    return (lvl > 255) ? 255 : lvl;
  endfunction

  // Result of one poll under the current register settings
  function automatic poll_result_t predict_poll(input logic [COUNT_W-1:0] count,
                                                input logic ok,
                                                input logic [LEVEL_W-1:0] cur,
                                                input logic present,
                                                input logic enable);
    poll_result_t r;
    int           tgt;
    int           stride;
    r.new_level     = cur;
    r.level_changed = 1'b0;
    r.lux_q8        = '0;
    r.lux_valid     = 1'b0;
    if (present && ok) begin
      r.lux_valid = 1'b1;
      r.lux_q8    = LUX_W'((64'(count) * 64'd9216) / 64'd625);
      if (enable) begin
        tgt = ramp_target(count);
        if (tgt != int'(cur)) begin
          stride = (tgt - int'(cur)) / 4;
          if (stride == 0) begin
            stride = (tgt > int'(cur)) ? 1 : -1;
          end
          r.new_level     = LEVEL_W'(int'(cur) + stride);
          r.level_changed = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Compare results, queue predictions, track register writes
  always @(posedge clk) begin : watch
    poll_result_t want;
    if (rst) begin
      present_r = 1'b1;
      enable_r  = 1'b1;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no poll outstanding");
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (new_level !== want.new_level) begin
            $error("new_level expected %0d actual %0d", want.new_level, new_level);
            fails++;
          end
          if (level_changed !== want.level_changed) begin
            $error("level_changed expected %0d actual %0d", want.level_changed,
                   level_changed);
            fails++;
          end
          if (lux_q8 !== want.lux_q8) begin
            $error("lux_q8 expected %0d actual %0d", want.lux_q8, lux_q8);
            fails++;
          end
          if (lux_valid !== want.lux_valid) begin
            $error("lux_valid expected %0d actual %0d", want.lux_valid, lux_valid);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(predict_poll(raw_count, read_ok, current_level,
                                               present_r, enable_r));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENSOR_PRESENT: begin
            present_r = cfg_data[0];
          end
          REG_AUTO_DIM_ENABLE: begin
            enable_r = cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
    owed_r <= pending_results.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for ambient_light_backlight_auto_dim: directed and random
// polls across register settings, checked by alad_checker. Depends on alad_pkg.
module tb;
  import alad_pkg::*;

  localparam int RESULT_LATENCY = LOG_FRACTION_BITS_DEF + 5;
  localparam int STALL_LIMIT    = 2000;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [COUNT_W-1:0]     raw_count;
  logic                   read_ok;
  logic [LEVEL_W-1:0]     current_level;
  logic                   done;
  logic [LEVEL_W-1:0]     new_level;
  logic                   level_changed;
  logic [LUX_W-1:0]       lux_q8;
  logic                   lux_valid;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatch_count;
  int results_owed;
  int stall_cycles = 0;
  bit idle_on      = 1'b1;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  ambient_light_backlight_auto_dim i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_count(raw_count), .read_ok(read_ok), .current_level(current_level),
    .done(done), .new_level(new_level), .level_changed(level_changed),
    .lux_q8(lux_q8), .lux_valid(lux_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  alad_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_count(raw_count), .read_ok(read_ok), .current_level(current_level),
    .done(done), .new_level(new_level), .level_changed(level_changed),
    .lux_q8(lux_q8), .lux_valid(lux_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  // Abort when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Hold start low for a random number of cycles
  task automatic idle_gap();
    while (idle_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offer one poll and wait until it is taken
  task automatic send_poll(input logic [COUNT_W-1:0] count, input logic ok,
                           input logic [LEVEL_W-1:0] level);
    idle_gap();
    start         <= 1'b1;
    raw_count     <= count;
    read_ok       <= ok;
    current_level <= level;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Poll weighted toward the ramp, its edges and small level steps
  task automatic send_random_poll();
    logic [COUNT_W-1:0] count;
    logic [LEVEL_W-1:0] level;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      count = COUNT_W'($urandom_range(17361, 87));
    end else if (pick < 60) begin
      count = COUNT_W'($urandom_range(200));
    end else if (pick < 70) begin
      count = COUNT_W'(($urandom_range(1) ? 16'd84 : 16'd17359) + $urandom_range(6));
    end else begin
      count = COUNT_W'($urandom);
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      level = LEVEL_W'(8'd57 + $urandom_range(6));
    end else if (pick == 1) begin
      level = LEVEL_W'(8'd252 + $urandom_range(3));
    end else begin
      level = LEVEL_W'($urandom);
    end
    send_poll(count, $urandom_range(99) < 90, level);
  endtask

  // Stop offering polls and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) begin
      @(posedge clk);
    end
  endtask

  // One register write; the caller lowers cfg_valid afterwards
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
  endtask

  // Drain, then write a stray index and both registers with noise in the upper bits
  task automatic apply_settings(input logic present, input logic enable);
    drain();
    write_reg(CFG_INDEX_W'($urandom_range(255, 2)), CFG_DATA_W'($urandom));
    write_reg(REG_SENSOR_PRESENT, {7'($urandom), present});
    write_reg(REG_AUTO_DIM_ENABLE, {7'($urandom), enable});
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    start         = 1'b0;
    raw_count     = '0;
    read_ok       = 1'b0;
    current_level = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    rst           = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: ramp edges, holds, single steps, failed reads, each setting
    send_poll(16'd0, 1'b1, 8'd60);
    send_poll(16'd0, 1'b1, 8'd61);
    send_poll(16'd0, 1'b1, 8'd59);
    send_poll(16'd86, 1'b1, 8'd0);
    send_poll(16'd87, 1'b1, 8'd255);
    send_poll(16'd88, 1'b1, 8'd128);
    send_poll(16'd1000, 1'b1, 8'd100);
    send_poll(16'd17361, 1'b1, 8'd0);
    send_poll(16'd17362, 1'b1, 8'd0);
    send_poll(16'hFFFF, 1'b1, 8'd255);
    send_poll(16'hFFFF, 1'b1, 8'd254);
    send_poll(16'hFFFF, 1'b0, 8'd0);
    send_poll(16'd0, 1'b0, 8'd255);
    apply_settings(1'b0, 1'b1);
    send_poll(16'hFFFF, 1'b1, 8'd0);
    send_poll(16'd1000, 1'b1, 8'd200);
    apply_settings(1'b1, 1'b0);
    send_poll(16'hFFFF, 1'b1, 8'd0);
    send_poll(16'd0, 1'b0, 8'd128);
    apply_settings(1'b0, 1'b0);
    send_poll(16'd1000, 1'b1, 8'd7);
    apply_settings(1'b1, 1'b1);

    // Random: long default phase with one full pause part-way
    for (n = 0; n < 900; n++) begin
      if (n == 450) begin
        drain();
      end
      send_random_poll();
    end
    // Back-to-back polls with no gaps
    idle_on = 1'b0;
    for (n = 0; n < 400; n++) begin
      send_random_poll();
    end
    idle_on = 1'b1;
    apply_settings(1'b0, 1'b1);
    for (n = 0; n < 150; n++) begin
      send_random_poll();
    end
    apply_settings(1'b1, 1'b0);
    for (n = 0; n < 150; n++) begin
      send_random_poll();
    end
    apply_settings(1'b0, 1'b0);
    for (n = 0; n < 100; n++) begin
      send_random_poll();
    end
    apply_settings(1'b1, 1'b1);
    for (n = 0; n < 300; n++) begin
      send_random_poll();
    end

    // Settle and give the verdict
    drain();
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/alad_pkg.sv
rtl/alad_lux.sv
rtl/alad_log2.sv
rtl/alad_level.sv
rtl/ambient_light_backlight_auto_dim.sv
bench/alad_checker.sv
bench/tb.sv
